### src/assert_macros.svh
// shared assertion macros for the block checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/efr_pkg.sv
`timescale 1ns / 1ps

package efr_pkg;

    localparam int PACKET_LEN = 64;
    localparam logic [7:0] LAST_SLOT = 8'(PACKET_LEN - 1);

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_START = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_BOOT  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_DISCOVER = 3'd1,
        EV_MESSAGE  = 3'd2,
        EV_BOOT     = 3'd3,
        EV_QUERY    = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        CFG_ESCAPE     = 3'd0,
        CFG_START      = 3'd1,
        CFG_QUERY      = 3'd2,
        CFG_DISCOVER   = 3'd3,
        CFG_BOOTLOADER = 3'd4,
        CFG_STOP       = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] escape_code;
        logic [7:0] start_code;
        logic [7:0] query_code;
        logic [7:0] discover_code;
        logic [7:0] bootloader_code;
        logic [7:0] stop_code;
    } t_cfg;

    typedef struct packed {
        logic       escape_pending;
        t_kind      open_frame_kind;
        logic [7:0] stored_length;
        t_event     latched_event;
    } t_state;

    typedef struct packed {
        t_event     event_res;
        logic       byte_written;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        t_event     last_event_type;
    } t_result;

endpackage

### src/efr_if.sv
`timescale 1ns / 1ps

interface efr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface efr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic       byte_written;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    logic [2:0] last_event_type;

    modport source (
        output valid, output event_res, output byte_written, output byte_value,
        output byte_index, output frame_length, output last_event_type, input ready
    );
    modport sink (
        input valid, input event_res, input byte_written, input byte_value,
        input byte_index, input frame_length, input last_event_type, output ready
    );
endinterface

### src/efr_cfg_regs.sv
`timescale 1ns / 1ps

module efr_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [2:0]    i_idx,
    input  logic [7:0]    i_data,
    output efr_pkg::t_cfg o_cfg
);
    import efr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escape_code     <= 8'd92;
            r_cfg.start_code      <= 8'd48;
            r_cfg.query_code      <= 8'd49;
            r_cfg.discover_code   <= 8'd50;
            r_cfg.bootloader_code <= 8'd51;
            r_cfg.stop_code       <= 8'd52;
        end else if (i_we) begin
            case (t_cfg_idx'(i_idx))
                CFG_ESCAPE:     r_cfg.escape_code     <= i_data;
                CFG_START:      r_cfg.start_code      <= i_data;
                CFG_QUERY:      r_cfg.query_code      <= i_data;
                CFG_DISCOVER:   r_cfg.discover_code   <= i_data;
                CFG_BOOTLOADER: r_cfg.bootloader_code <= i_data;
                CFG_STOP:       r_cfg.stop_code       <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/efr_step_logic.sv
`timescale 1ns / 1ps

module efr_step_logic (
    input  efr_pkg::t_cfg    i_cfg,
    input  efr_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    output efr_pkg::t_state  o_state,
    output efr_pkg::t_result o_result
);
    import efr_pkg::*;

    logic       data;
    t_event     ev;
    logic [8:0] len_inc;
    t_state     n_state;

    always_comb begin
        n_state = i_state;
        ev      = EV_NONE;
        data    = 1'b1;
        len_inc = {1'b0, i_state.stored_length} + 9'd1;

        if (!i_state.escape_pending && i_byte == i_cfg.escape_code) begin
            n_state.escape_pending = 1'b1;
            data = 1'b0;
        end else if (i_state.escape_pending) begin
            n_state.escape_pending = 1'b0;
            data = 1'b0;
            if (i_byte == i_cfg.start_code) begin
                n_state.open_frame_kind = KIND_START;
                n_state.stored_length   = 8'd0;
            end else if (i_byte == i_cfg.query_code) begin
                n_state.open_frame_kind = KIND_QUERY;
                n_state.stored_length   = 8'd0;
            end else if (i_byte == i_cfg.discover_code) begin
                ev = EV_DISCOVER;
            end else if (i_byte == i_cfg.bootloader_code) begin
                n_state.open_frame_kind = KIND_BOOT;
                n_state.stored_length   = 8'd0;
            end else if (i_byte == i_cfg.stop_code) begin
                if (i_state.open_frame_kind == KIND_START) begin
                    ev = EV_MESSAGE;
                end else if (i_state.open_frame_kind == KIND_BOOT) begin
                    ev = EV_BOOT;
                end
                n_state.open_frame_kind = KIND_NONE;
            end else begin
                data = 1'b1;
            end
        end

        if (data) begin
            // index saturates at the last slot
            if (len_inc >= 9'(PACKET_LEN)) begin
                n_state.stored_length = LAST_SLOT;
            end else begin
                n_state.stored_length = len_inc[7:0];
            end
            if (i_state.open_frame_kind == KIND_QUERY) begin
                n_state.open_frame_kind = KIND_NONE;
                ev = EV_QUERY;
            end
        end

        if (ev != EV_NONE) begin
            n_state.latched_event = ev;
        end

        o_state                  = n_state;
        o_result.event_res       = ev;
        o_result.byte_written    = data;
        o_result.byte_value      = data ? i_byte : 8'd0;
        o_result.byte_index      = data ? i_state.stored_length : 8'd0;
        o_result.frame_length    = n_state.stored_length;
        o_result.last_event_type = n_state.latched_event;
    end

endmodule

### src/escaped_frame_receiver_core.sv
`timescale 1ns / 1ps

// channel   direction  payload
// i_rx      in         rx_byte
// o_res     out        event_res, byte_written, byte_value, byte_index,
//                      frame_length, last_event_type
// i_cfg_*   in         write enable, register index, 8-bit data
//
// one result per byte, valid once the byte has passed the input register and then the output register
// one byte per cycle sustained while o_res.ready holds; the frame state register closes the only loop
// synchronous active-low reset clears state and valid flags, reloads default codes
// a stalled result holds in the output register while one more byte waits
// in the input register; i_rx.ready drops only when both are full

module escaped_frame_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    efr_in_if.sink      i_rx,
    efr_out_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import efr_pkg::*;

    t_cfg       cfg;
    t_state     r_state;
    t_state     n_state;
    t_result    n_res;
    t_result    r_res;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       advance;

    efr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    efr_step_logic u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (n_res)
    );

    assign advance    = !r_out_valid || o_res.ready;
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid           <= 1'b0;
            r_state.escape_pending  <= 1'b0;
            r_state.open_frame_kind <= KIND_NONE;
            r_state.stored_length   <= 8'd0;
            r_state.latched_event   <= EV_NONE;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.event_res       = r_res.event_res;
    assign o_res.byte_written    = r_res.byte_written;
    assign o_res.byte_value      = r_res.byte_value;
    assign o_res.byte_index      = r_res.byte_index;
    assign o_res.frame_length    = r_res.frame_length;
    assign o_res.last_event_type = r_res.last_event_type;

endmodule

### src/efr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module efr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_event_res,
    input logic       i_byte_written,
    input logic [7:0] i_byte_value,
    input logic [7:0] i_byte_index,
    input logic [7:0] i_frame_length,
    input logic [2:0] i_last_event_type
);
    import efr_pkg::*;

    `ASSERT_ALWAYS(a_reset_idle, i_clk,
        !i_rst_n |=> !i_out_valid,
        "result valid after reset")

    `ASSERT_RUN(a_valid_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid,
        "result dropped while stalled")

    `ASSERT_RUN(a_no_write_zero, i_clk, i_rst_n,
        i_out_valid && !i_byte_written |-> i_byte_value == 8'd0 && i_byte_index == 8'd0,
        "unwritten byte fields not zero")

    `ASSERT_RUN(a_event_latched, i_clk, i_rst_n,
        i_out_valid && i_event_res != EV_NONE |-> i_last_event_type == i_event_res,
        "last event does not follow reported event")

    `ASSERT_RUN(a_length_bound, i_clk, i_rst_n,
        i_out_valid |-> i_frame_length <= LAST_SLOT && i_byte_index <= LAST_SLOT,
        "length or index past last slot")

endmodule

bind escaped_frame_receiver_core efr_checker u_efr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_event_res       (o_res.event_res),
    .i_byte_written    (o_res.byte_written),
    .i_byte_value      (o_res.byte_value),
    .i_byte_index      (o_res.byte_index),
    .i_frame_length    (o_res.frame_length),
    .i_last_event_type (o_res.last_event_type)
);
